// File: rtl/qrs_pkg.sv
// shared types and constants for the quadratic root solver
package qrs_pkg;

   localparam int COEF_BITS = 16;
   localparam int FRAC_BITS = 8;
   localparam int DISC_W    = 2 * COEF_BITS + 2;
   localparam int ROOT_W    = DISC_W / 2;
   localparam int NUM_W     = COEF_BITS + 3;
   localparam int MAG_W     = COEF_BITS + 1;
   localparam int QUO_W     = MAG_W + 2 * FRAC_BITS;
   localparam int DEN_W     = COEF_BITS + 1;
   localparam int OUT_W     = 32;

   typedef enum logic [1:0] {
      KIND_TWO    = 2'd0,
      KIND_DOUBLE = 2'd1,
      KIND_NONE   = 2'd2,
      KIND_AZERO  = 2'd3
   } kind_type;

   typedef struct packed {
      kind_type                       kind;
      logic signed [DISC_W-1:0]       disc;
      logic signed [COEF_BITS-1:0]    a;
      logic signed [COEF_BITS-1:0]    b;
      logic                           neg_p;
      logic                           neg_m;
   } side_type;

endpackage

// File: rtl/qrs_sqrt_pipe.sv
// pipelined integer square root, one result bit per stage
module qrs_sqrt_pipe (
   input  logic                          clock,
   input  logic                          en,
   input  logic [qrs_pkg::DISC_W-1:0]    rad,
   output logic [qrs_pkg::ROOT_W-1:0]    root
);
   import qrs_pkg::*;

   localparam int REM_W = ROOT_W + 3;

   logic [DISC_W-1:0] rad_ff  [0:ROOT_W];
   logic [ROOT_W-1:0] root_ff [0:ROOT_W];
   logic [REM_W-1:0]  rem_ff  [0:ROOT_W];

   always_comb begin
      rad_ff[0]  = rad;
      root_ff[0] = '0;
      rem_ff[0]  = '0;
   end

   for (genvar k = 0; k < ROOT_W; k++) begin : g_stage
      logic [REM_W-1:0]  rem_in;
      logic [REM_W-1:0]  trial_in;
      logic              take_in;

      always_comb begin
         rem_in   = {rem_ff[k][REM_W-3:0], rad_ff[k][DISC_W-1 -: 2]};
         trial_in = {root_ff[k][ROOT_W-2:0], 2'b01};
         take_in  = (rem_in >= trial_in);
      end

      always_ff @(posedge clock) begin
         if (en) begin
            rad_ff[k+1]  <= {rad_ff[k][DISC_W-3:0], 2'b00};
            root_ff[k+1] <= {root_ff[k][ROOT_W-2:0], take_in};
            rem_ff[k+1]  <= take_in ? (rem_in - trial_in) : rem_in;
         end
      end
   end

   assign root = root_ff[ROOT_W];

endmodule

// File: rtl/qrs_div_pipe.sv
// pipelined unsigned restoring divider, one quotient bit per stage
module qrs_div_pipe (
   input  logic                          clock,
   input  logic                          en,
   input  logic [qrs_pkg::QUO_W-1:0]     dividend,
   input  logic [qrs_pkg::DEN_W-1:0]     divisor,
   output logic [qrs_pkg::QUO_W-1:0]     quotient
);
   import qrs_pkg::*;

   logic [QUO_W-1:0] dq_ff  [0:QUO_W];
   logic [DEN_W-1:0] den_ff [0:QUO_W];
   logic [DEN_W-1:0] rem_ff [0:QUO_W];

   always_comb begin
      dq_ff[0]  = dividend;
      den_ff[0] = divisor;
      rem_ff[0] = '0;
   end

   for (genvar k = 0; k < QUO_W; k++) begin : g_stage
      logic [DEN_W:0] part_in;
      logic           take_in;

      always_comb begin
         part_in = {rem_ff[k], dq_ff[k][QUO_W-1]};
         take_in = (part_in >= {1'b0, den_ff[k]});
      end

      always_ff @(posedge clock) begin
         if (en) begin
            dq_ff[k+1]  <= {dq_ff[k][QUO_W-2:0], take_in};
            den_ff[k+1] <= den_ff[k];
            rem_ff[k+1] <= take_in ? DEN_W'(part_in - {1'b0, den_ff[k]})
                                   : part_in[DEN_W-1:0];
         end
      end
   end

   assign quotient = dq_ff[QUO_W];

endmodule

// File: rtl/quadratic_root_solver_top.sv
// quadratic root solver: discriminant, square root and two root quotients
// throughput: one beat per cycle; the whole pipeline holds while a response beat waits
// stages: 2 for the discriminant, 17 square root, 1 numerator, 33 divide, 1 output
// reset clears all valid bits; data registers are not reset
module quadratic_root_solver_top (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_ready,
   input  logic signed [qrs_pkg::COEF_BITS-1:0] req_coef_a,
   input  logic signed [qrs_pkg::COEF_BITS-1:0] req_coef_b,
   input  logic signed [qrs_pkg::COEF_BITS-1:0] req_coef_c,
   output logic                                rsp_valid,
   input  logic                                rsp_ready,
   output logic [1:0]                          rsp_root_kind,
   output logic signed [qrs_pkg::OUT_W-1:0]    rsp_root_plus,
   output logic signed [qrs_pkg::OUT_W-1:0]    rsp_root_minus,
   output logic signed [qrs_pkg::DISC_W-1:0]   rsp_discriminant
);
   import qrs_pkg::*;

   localparam int PROD_W = 2 * COEF_BITS;

   function automatic logic [OUT_W-1:0] sat_fn(input logic [QUO_W-1:0] q, input logic neg);
      logic [QUO_W-1:0] lim;
      lim = QUO_W'(1) << (OUT_W - 1);
      if (neg) begin
         sat_fn = (q > lim) ? lim[OUT_W-1:0] : OUT_W'(-q);
      end else begin
         sat_fn = (q > lim - QUO_W'(1)) ? (lim[OUT_W-1:0] - OUT_W'(1)) : q[OUT_W-1:0];
      end
   endfunction

   logic adv;
   assign adv       = !rsp_valid || rsp_ready;
   assign req_ready = adv;

   // stage 1: products
   logic                        v1_ff;
   logic signed [PROD_W-1:0]    bb_ff, ac_ff;
   logic signed [COEF_BITS-1:0] a1_ff, b1_ff;

   // stage 2: discriminant
   logic     v2_ff;
   side_type s2_ff;
   side_type s2_in;

   always_comb begin
      s2_in       = '0;
      s2_in.a     = a1_ff;
      s2_in.b     = b1_ff;
      s2_in.disc  = DISC_W'(bb_ff) - (DISC_W'(ac_ff) <<< 2);
      if (a1_ff == '0) begin
         s2_in.kind = KIND_AZERO;
      end else if (s2_in.disc[DISC_W-1]) begin
         s2_in.kind = KIND_NONE;
      end else if (s2_in.disc == '0) begin
         s2_in.kind = KIND_DOUBLE;
      end else begin
         s2_in.kind = KIND_TWO;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         bb_ff <= req_coef_b * req_coef_b;
         ac_ff <= req_coef_a * req_coef_c;
         a1_ff <= req_coef_a;
         b1_ff <= req_coef_b;
         s2_ff <= s2_in;
      end
   end

   // square root section
   logic [ROOT_W-1:0] sq_root;
   logic [DISC_W-1:0] sq_rad;
   assign sq_rad = s2_ff.disc[DISC_W-1] ? '0 : s2_ff.disc;

   qrs_sqrt_pipe u_sqrt (
      .clock (clock),
      .en    (adv),
      .rad   (sq_rad),
      .root  (sq_root)
   );

   side_type sq_side_ff [0:ROOT_W];
   logic     sq_v_ff    [0:ROOT_W];

   always_comb begin
      sq_side_ff[0] = s2_ff;
      sq_v_ff[0]    = v2_ff;
   end

   for (genvar k = 0; k < ROOT_W; k++) begin : g_sq_side
      always_ff @(posedge clock) begin
         if (adv) sq_side_ff[k+1] <= sq_side_ff[k];
      end
      always_ff @(posedge clock) begin
         if (reset) begin
            sq_v_ff[k+1] <= 1'b0;
         end else if (adv) begin
            sq_v_ff[k+1] <= sq_v_ff[k];
         end
      end
   end

   // stage 3: signed numerators to magnitudes
   side_type               sq_out;
   logic signed [NUM_W-1:0] nb_in, np_in, nm_in, rx_in;
   logic [MAG_W-1:0]        mp_in, mm_in;
   logic signed [DEN_W-1:0] den_in;
   logic [DEN_W-1:0]        dmag_in;
   side_type                s3_in;

   always_comb begin
      sq_out  = sq_side_ff[ROOT_W];
      nb_in   = -NUM_W'(sq_out.b);
      rx_in   = $signed(NUM_W'(sq_root));
      np_in   = nb_in + rx_in;
      nm_in   = nb_in - rx_in;
      mp_in   = np_in[NUM_W-1] ? MAG_W'(-np_in) : MAG_W'(np_in);
      mm_in   = nm_in[NUM_W-1] ? MAG_W'(-nm_in) : MAG_W'(nm_in);
      den_in  = {sq_out.a, 1'b0};
      dmag_in = den_in[DEN_W-1] ? DEN_W'(-den_in) : DEN_W'(den_in);
      s3_in       = sq_out;
      s3_in.neg_p = np_in[NUM_W-1] ^ sq_out.a[COEF_BITS-1];
      s3_in.neg_m = nm_in[NUM_W-1] ^ sq_out.a[COEF_BITS-1];
   end

   logic             v3_ff;
   side_type         s3_ff;
   logic [QUO_W-1:0] nump_ff, numm_ff;
   logic [DEN_W-1:0] den_ff;

   always_ff @(posedge clock) begin
      if (adv) begin
         s3_ff   <= s3_in;
         nump_ff <= {mp_in, {(2 * FRAC_BITS){1'b0}}};
         numm_ff <= {mm_in, {(2 * FRAC_BITS){1'b0}}};
         den_ff  <= dmag_in;
      end
   end

   // divide section
   logic [QUO_W-1:0] qp, qm;

   qrs_div_pipe u_div_plus (
      .clock    (clock),
      .en       (adv),
      .dividend (nump_ff),
      .divisor  (den_ff),
      .quotient (qp)
   );

   qrs_div_pipe u_div_minus (
      .clock    (clock),
      .en       (adv),
      .dividend (numm_ff),
      .divisor  (den_ff),
      .quotient (qm)
   );

   side_type dv_side_ff [0:QUO_W];
   logic     dv_v_ff    [0:QUO_W];

   always_comb begin
      dv_side_ff[0] = s3_ff;
      dv_v_ff[0]    = v3_ff;
   end

   for (genvar k = 0; k < QUO_W; k++) begin : g_dv_side
      always_ff @(posedge clock) begin
         if (adv) dv_side_ff[k+1] <= dv_side_ff[k];
      end
      always_ff @(posedge clock) begin
         if (reset) begin
            dv_v_ff[k+1] <= 1'b0;
         end else if (adv) begin
            dv_v_ff[k+1] <= dv_v_ff[k];
         end
      end
   end

   // output register
   side_type         dv_out;
   logic [OUT_W-1:0] rp_in, rm_in;
   logic             rsp_valid_ff;
   logic [1:0]       kind_ff;
   logic [OUT_W-1:0] rp_ff, rm_ff;
   logic [DISC_W-1:0] disc_ff;

   always_comb begin
      dv_out = dv_side_ff[QUO_W];
      if (dv_out.kind == KIND_NONE || dv_out.kind == KIND_AZERO) begin
         rp_in = '0;
         rm_in = '0;
      end else begin
         rp_in = sat_fn(qp, dv_out.neg_p);
         rm_in = sat_fn(qm, dv_out.neg_m);
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         kind_ff <= dv_out.kind;
         rp_ff   <= rp_in;
         rm_ff   <= rm_in;
         disc_ff <= dv_out.disc;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff        <= 1'b0;
         v2_ff        <= 1'b0;
         v3_ff        <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else if (adv) begin
         v1_ff        <= req_valid;
         v2_ff        <= v1_ff;
         v3_ff        <= sq_v_ff[ROOT_W];
         rsp_valid_ff <= dv_v_ff[QUO_W];
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_root_kind    = kind_ff;
   assign rsp_root_plus    = $signed(rp_ff);
   assign rsp_root_minus   = $signed(rm_ff);
   assign rsp_discriminant = $signed(disc_ff);

   // no roots reported means both root fields are zero
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_root_kind == KIND_NONE || rsp_root_kind == KIND_AZERO)
      |-> (rsp_root_plus == '0 && rsp_root_minus == '0))
      else $error("roots not zero without real roots");

   // a double root gives the same value in both fields
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_root_kind == KIND_DOUBLE |-> rsp_root_plus == rsp_root_minus)
      else $error("double root fields differ");

   // a stalled response beat holds its discriminant and kind
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_discriminant)
      && $stable(rsp_root_kind))
      else $error("stalled response changed");

   // kind agrees with the discriminant sign when a is nonzero
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_root_kind != KIND_AZERO
      |-> (rsp_discriminant[DISC_W-1] == (rsp_root_kind == KIND_NONE)))
      else $error("kind and discriminant sign disagree");

endmodule

// File: dv/testbench.sv
// self-checking testbench for the quadratic root solver: directed table plus random beats
`timescale 1ns / 100ps

module testbench;
   import qrs_pkg::*;

   typedef struct {
      logic signed [COEF_BITS-1:0] a;
      logic signed [COEF_BITS-1:0] b;
      logic signed [COEF_BITS-1:0] c;
   } coef_set_type;

   typedef struct {
      logic [1:0]               kind;
      logic signed [OUT_W-1:0]  rp;
      logic signed [OUT_W-1:0]  rm;
      logic signed [DISC_W-1:0] disc;
   } roots_type;

   localparam int N_DIRECTED = 16;
   localparam int N_RANDOM   = 1100;
   localparam int WATCHDOG   = 4000;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_ready;
   logic signed [COEF_BITS-1:0] req_coef_a = '0;
   logic signed [COEF_BITS-1:0] req_coef_b = '0;
   logic signed [COEF_BITS-1:0] req_coef_c = '0;
   logic rsp_valid;
   logic rsp_ready = 1'b0;
   logic [1:0] rsp_root_kind;
   logic signed [OUT_W-1:0] rsp_root_plus;
   logic signed [OUT_W-1:0] rsp_root_minus;
   logic signed [DISC_W-1:0] rsp_discriminant;

   roots_type expected_roots[$];
   int errors = 0;
   int idle_cycles = 0;
   bit calm = 1'b0;

   always #2 clock = ~clock;

   quadratic_root_solver_top u_dut (.*);

   function automatic longint signed isqrt(longint signed x);
      longint signed r;
      longint signed lo;
      longint signed hi;
      lo = 0;
      hi = 131072;
      while (lo < hi) begin
         r = (lo + hi + 1) / 2;
         if (r * r <= x) lo = r;
         else hi = r - 1;
      end
      return lo;
   endfunction

   function automatic logic signed [OUT_W-1:0] quot_sat(longint signed num,
                                                        longint signed den);
      longint signed q;
      q = (num * (64'sd1 <<< (2 * FRAC_BITS))) / den;
      if (q > 64'sd2147483647) q = 64'sd2147483647;
      if (q < -64'sd2147483648) q = -64'sd2147483648;
      return q[OUT_W-1:0];
   endfunction

   function automatic roots_type solve_roots(coef_set_type cs);
      roots_type r;
      longint signed a;
      longint signed b;
      longint signed c;
      longint signed d;
      longint signed s;
      a = cs.a;
      b = cs.b;
      c = cs.c;
      d = b * b - 4 * a * c;
      r.disc = d[DISC_W-1:0];
      r.rp = '0;
      r.rm = '0;
      if (a == 0) r.kind = KIND_AZERO;
      else if (d < 0) r.kind = KIND_NONE;
      else begin
         s = isqrt(d);
         r.kind = (d == 0) ? KIND_DOUBLE : KIND_TWO;
         r.rp = quot_sat(-b + s, 2 * a);
         r.rm = quot_sat(-b - s, 2 * a);
      end
      return r;
   endfunction

   // directed rows; check_row marks rows whose result is typed in
   coef_set_type directed_coefs[N_DIRECTED];
   roots_type    directed_roots[N_DIRECTED];
   bit           check_row[N_DIRECTED];

   task automatic set_row(int i, int a, int b, int c, bit typed, roots_type r);
      directed_coefs[i] = '{a[15:0], b[15:0], c[15:0]};
      check_row[i] = typed;
      directed_roots[i] = r;
   endtask

   initial begin
      roots_type z;
      z = '{KIND_AZERO, 0, 0, 0};
      set_row(0, 0, 0, 0, 1, z);
      set_row(1, 0, -32768, 32767, 1, '{KIND_AZERO, 0, 0, 34'sd1073741824});
      set_row(2, 0, 32767, -32768, 1, '{KIND_AZERO, 0, 0, 34'sd1073676289});
      set_row(3, 32767, 0, 32767, 1, '{KIND_NONE, 0, 0, -34'sd4294705156});
      set_row(4, -32768, 0, -32768, 1, '{KIND_NONE, 0, 0, -34'sd4294967296});
      set_row(5, -32768, -32768, 32767, 0, z);
      set_row(6, 32767, 32767, -32768, 0, z);
      set_row(7, 256, -512, 256, 0, z);
      set_row(8, 256, 0, -256, 0, z);
      set_row(9, 1, 1, 0, 0, z);
      set_row(10, 1, -32768, 0, 0, z);
      set_row(11, -1, 32767, 0, 0, z);
      set_row(12, 256, 0, 0, 0, z);
      set_row(13, 32767, 1, 0, 0, z);
      set_row(14, -32768, 32767, 32767, 0, z);
      set_row(15, 1, 0, -1, 0, z);
   end

   function automatic coef_set_type random_coefs();
      coef_set_type cs;
      int pick;
      cs.a = COEF_BITS'($urandom);
      cs.b = COEF_BITS'($urandom);
      cs.c = COEF_BITS'($urandom);
      pick = $urandom_range(0, 9);
      case (pick)
         0: cs.a = '0;
         1: cs.c = '0;
         2: begin
            cs.a = COEF_BITS'($urandom_range(1, 64));
            cs.c = COEF_BITS'($urandom_range(0, 64));
            cs.b = COEF_BITS'(2 * $urandom_range(0, 64));
            cs.c = ((cs.b * cs.b) / (4 * cs.a) == 0) ? '0 : cs.c;
         end
         3: cs.a = COEF_BITS'(int'($urandom_range(0, 3)) - 2);
         default: ;
      endcase
      return cs;
   endfunction

   task automatic send_beat(coef_set_type cs, bit typed, roots_type r);
      while (!calm && $urandom_range(0, 99) < 7) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_coef_a <= cs.a;
      req_coef_b <= cs.b;
      req_coef_c <= cs.c;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      expected_roots.push_back(typed ? r : solve_roots(cs));
   endtask

   always @(posedge clock) begin
      if (!reset) rsp_ready <= calm || ($urandom_range(0, 99) >= 7);
   end

   // compare each response beat with the oldest expectation
   always @(posedge clock) begin
      roots_type e;
      if (!reset && rsp_valid && rsp_ready) begin
         if (expected_roots.size() == 0) begin
            $display("%0t unexpected beat kind %0d", $time, rsp_root_kind);
            errors++;
         end else begin
            e = expected_roots.pop_front();
            if (rsp_root_kind !== e.kind) begin
               $display("%0t kind exp %0d got %0d", $time, e.kind, rsp_root_kind);
               errors++;
            end
            if (rsp_root_plus !== e.rp) begin
               $display("%0t root_plus exp %0d got %0d", $time, e.rp, rsp_root_plus);
               errors++;
            end
            if (rsp_root_minus !== e.rm) begin
               $display("%0t root_minus exp %0d got %0d", $time, e.rm, rsp_root_minus);
               errors++;
            end
            if (rsp_discriminant !== e.disc) begin
               $display("%0t disc exp %0d got %0d", $time, e.disc, rsp_discriminant);
               errors++;
            end
         end
      end
   end

   always @(posedge clock) begin
      if ((req_valid && req_ready) || (rsp_valid && rsp_ready)) idle_cycles = 0;
      else idle_cycles++;
      if (idle_cycles >= WATCHDOG) begin
         $display("[quadratic_root_solver_top] ERROR");
         $finish;
      end
   end

   initial begin
      roots_type z;
      z = '{KIND_TWO, 0, 0, 0};
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      for (int i = 0; i < N_DIRECTED; i++)
         send_beat(directed_coefs[i], check_row[i], directed_roots[i]);
      for (int i = 0; i < N_RANDOM; i++) begin
         // stretch with no idling on either side
         calm = (i >= 400 && i < 600);
         send_beat(random_coefs(), 1'b0, z);
      end
      req_valid <= 1'b0;
      calm = 1'b0;
      while (expected_roots.size() != 0) @(posedge clock);
      repeat (120) @(posedge clock);
      if (errors == 0) $display("[quadratic_root_solver_top] OK");
      else $display("[quadratic_root_solver_top] ERROR");
      $finish;
   end

endmodule
